// ----- sv/scd_pkg.sv -----
// Shared types and constants of the scanline dimmer.
`timescale 1ns / 1ps
`default_nettype none

package scd_pkg;

  // Widths of the pixel words and of the configuration fields.
  localparam int WORD_W    = 32;
  localparam int PCT_W     = 7;
  localparam int FACTOR_W  = 9;
  localparam int APB_AW    = 4;
  localparam int APB_DW    = 32;

  // Percentage at which the gap line is fully blanked.
  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  // Division by 100 as a multiply by a rounded-up reciprocal and a shift.
  // It is exact for every dividend below 2^15.
  localparam int RECIP_SHIFT = 21;
  localparam int RECIP_W     = 15;
  localparam logic [RECIP_W-1:0] RECIP_MUL = 15'd20972;

  // Channel masks for two packed RGB565 pixels.
  localparam logic [WORD_W-1:0] MASK_565_LO_IN  = 32'h07e0_f81f;
  localparam logic [WORD_W-1:0] MASK_565_HI_IN  = 32'h07c0_f83f;
  localparam logic [WORD_W-1:0] MASK_565_LO_OUT = 32'hfc1f_03e0;
  localparam logic [WORD_W-1:0] MASK_565_HI_OUT = 32'hf81f_07e0;

  // Channel masks for one ARGB8888 pixel.
  localparam logic [WORD_W-1:0] MASK_8888_RB_IN  = 32'h00ff_00ff;
  localparam logic [WORD_W-1:0] MASK_8888_RB_OUT = 32'hff00_ff00;
  localparam logic [WORD_W-1:0] MASK_8888_G      = 32'h0000_ff00;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_PERCENT = 2'd0;
  localparam logic [1:0] REG_INTERP  = 2'd1;
  localparam logic [1:0] REG_FORMAT  = 2'd2;

  // Pixel format codes.
  localparam logic FMT_RGB565   = 1'b0;
  localparam logic FMT_ARGB8888 = 1'b1;

  // What the datapath does with a word.
  typedef enum logic [1:0] {
    MODE_COPY  = 2'd0,
    MODE_BLANK = 2'd1,
    MODE_DIM   = 2'd2
  } mode_t;

  // Settings derived from the registers, handed to the datapath.
  typedef struct packed {
    mode_t               mode;
    logic                interp;
    logic                fmt;
    logic [FACTOR_W-1:0] factor;
  } ctrl_t;

endpackage

`default_nettype wire

// ----- sv/scd_in_if.sv -----
// Input channel: upper and lower pixel words with valid and ready.
`timescale 1ns / 1ps
`default_nettype none

interface scd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] upper_word;
  logic [31:0] lower_word;

  modport source (output valid, output upper_word, output lower_word, input ready);
  modport sink   (input valid, input upper_word, input lower_word, output ready);
endinterface

`default_nettype wire

// ----- sv/scd_out_if.sv -----
// Result channel: gap pixel word with valid and ready.
`timescale 1ns / 1ps
`default_nettype none

interface scd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] gap_word;

  modport source (output valid, output gap_word, input ready);
  modport sink   (input valid, input gap_word, output ready);
endinterface

`default_nettype wire

// ----- sv/scanline_dimmer_core.sv -----
// Top level of the scanline dimmer: configuration port and dimming pipeline.
// A beat passes the input register, then the result register, before it leaves.
// Throughput: one word per clock unless the result stalls, held by the input and result
// registers of the pipeline.
// A stalled result still lets one further beat into the input register.
// Reset (synchronous, active low) empties the pipeline and clears the configuration to 0.
// A configuration write takes effect for beats accepted from the cycle after it.
`timescale 1ns / 1ps
`default_nettype none

module scanline_dimmer_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  scd_in_if.sink           in_bus,
  scd_out_if.source        out_bus,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);

  scd_pkg::ctrl_t ctrl;

  // Register file and derived settings.
  scd_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .ctrl        (ctrl)
  );

  // Pixel pipeline.
  scd_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

endmodule

`default_nettype wire

// ----- sv/scd_cfg_regs.sv -----
// Configuration registers on the APB-style port and the derived dimming settings.
`timescale 1ns / 1ps
`default_nettype none

module scd_cfg_regs (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [scd_pkg::APB_AW-1:0] cfg_paddr,
  input  wire logic [scd_pkg::APB_DW-1:0] cfg_pwdata,
  output logic      [scd_pkg::APB_DW-1:0] cfg_prdata,
  output logic                            cfg_pready,
  output scd_pkg::ctrl_t                  ctrl
);

  logic [scd_pkg::PCT_W-1:0] pct_r, pct_nxt;
  logic                      interp_r, interp_nxt;
  logic                      fmt_r, fmt_nxt;
  scd_pkg::ctrl_t            ctrl_r, ctrl_nxt;

  logic                              wr_en;
  logic [1:0]                        reg_idx;
  logic [scd_pkg::PCT_W-1:0]         remain;
  logic [scd_pkg::RECIP_W-1:0]       scaled;
  logic [2*scd_pkg::RECIP_W-1:0]     recip_prod;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[3:2];

  // Register writes.
  always_comb begin
    pct_nxt    = pct_r;
    interp_nxt = interp_r;
    fmt_nxt    = fmt_r;
    if (wr_en) begin
      unique case (reg_idx)
        scd_pkg::REG_PERCENT: pct_nxt    = cfg_pwdata[scd_pkg::PCT_W-1:0];
        scd_pkg::REG_INTERP:  interp_nxt = cfg_pwdata[0];
        scd_pkg::REG_FORMAT:  fmt_nxt    = cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  // Read-back of the registers.
  always_comb begin
    unique case (reg_idx)
      scd_pkg::REG_PERCENT: cfg_prdata = {{(scd_pkg::APB_DW-scd_pkg::PCT_W){1'b0}}, pct_r};
      scd_pkg::REG_INTERP:  cfg_prdata = {{(scd_pkg::APB_DW-1){1'b0}}, interp_r};
      scd_pkg::REG_FORMAT:  cfg_prdata = {{(scd_pkg::APB_DW-1){1'b0}}, fmt_r};
      default:              cfg_prdata = '0;
    endcase
  end

  // Brightness factor: (100 - pct) scaled by 16, 32, 128 or 256, then divided by 100.
  // Halving the divisor for interpolation is folded into the scale.
  always_comb begin
    remain = scd_pkg::PCT_FULL - pct_r;
    unique case ({fmt_r, interp_r})
      2'b00:   scaled = {3'd0, remain, 5'd0};
      2'b01:   scaled = {4'd0, remain, 4'd0};
      2'b10:   scaled = {remain[6:0], 8'd0};
      default: scaled = {1'b0, remain, 7'd0};
    endcase
    recip_prod = scaled * scd_pkg::RECIP_MUL;

    ctrl_nxt.interp = interp_r;
    ctrl_nxt.fmt    = fmt_r;
    ctrl_nxt.factor = recip_prod[scd_pkg::RECIP_SHIFT +: scd_pkg::FACTOR_W];
    if (pct_r >= scd_pkg::PCT_FULL) begin
      ctrl_nxt.mode = scd_pkg::MODE_BLANK;
    end else if (pct_r == '0) begin
      ctrl_nxt.mode = scd_pkg::MODE_COPY;
    end else begin
      ctrl_nxt.mode = scd_pkg::MODE_DIM;
    end
  end

  // The derived settings are registered, so the factor multiply does not
  // chain into the channel multiplies of the datapath.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pct_r    <= '0;
      interp_r <= 1'b0;
      fmt_r    <= scd_pkg::FMT_RGB565;
      ctrl_r   <= '{mode: scd_pkg::MODE_COPY, interp: 1'b0, fmt: scd_pkg::FMT_RGB565,
                    factor: '0};
    end else begin
      pct_r    <= pct_nxt;
      interp_r <= interp_nxt;
      fmt_r    <= fmt_nxt;
      ctrl_r   <= ctrl_nxt;
    end
  end

  assign ctrl = ctrl_r;

endmodule

`default_nettype wire

// ----- sv/scd_datapath.sv -----
// Two-stage pipeline: input register, channel dimming, result register.
`timescale 1ns / 1ps
`default_nettype none

module scd_datapath (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire scd_pkg::ctrl_t ctrl,
  scd_in_if.sink              in_bus,
  scd_out_if.source           out_bus
);

  localparam int W = scd_pkg::WORD_W;

  logic         s1_v_r, s1_v_nxt;
  logic [W-1:0] s1_up_r, s1_lo_r;
  logic         out_v_r, out_v_nxt;
  logic [W-1:0] out_d_r, out_d_nxt;

  logic         out_adv, s1_adv;
  logic [W-1:0] lo_565, hi_565, rb_8888;
  logic [8:0]   g_8888;
  logic [W-1:0] op_a, op_b, prod_a, prod_b, dimmed;
  logic [W-1:0] factor_w;

  // Flow control: each stage moves when the one after it has room.
  assign out_adv      = !out_v_r || out_bus.ready;
  assign s1_adv       = !s1_v_r || out_adv;
  assign in_bus.ready = s1_adv;

  assign s1_v_nxt  = s1_adv ? in_bus.valid : s1_v_r;
  assign out_v_nxt = out_adv ? s1_v_r : out_v_r;

  // Channel extraction, summed with the lower word when interpolating.
  always_comb begin
    if (ctrl.interp) begin
      lo_565  = (s1_up_r & scd_pkg::MASK_565_LO_IN) + (s1_lo_r & scd_pkg::MASK_565_LO_IN);
      hi_565  = ((s1_up_r >> 5) & scd_pkg::MASK_565_HI_IN)
              + ((s1_lo_r >> 5) & scd_pkg::MASK_565_HI_IN);
      rb_8888 = (s1_up_r & scd_pkg::MASK_8888_RB_IN) + (s1_lo_r & scd_pkg::MASK_8888_RB_IN);
      g_8888  = {1'b0, s1_up_r[15:8]} + {1'b0, s1_lo_r[15:8]};
    end else begin
      lo_565  = s1_up_r & scd_pkg::MASK_565_LO_IN;
      hi_565  = (s1_up_r >> 5) & scd_pkg::MASK_565_HI_IN;
      rb_8888 = s1_up_r & scd_pkg::MASK_8888_RB_IN;
      g_8888  = {1'b0, s1_up_r[15:8]};
    end
  end

  // Two shared multipliers; both formats keep the low 32 bits of each product.
  always_comb begin
    factor_w = {{(W-scd_pkg::FACTOR_W){1'b0}}, ctrl.factor};
    if (ctrl.fmt == scd_pkg::FMT_ARGB8888) begin
      op_a = rb_8888;
      op_b = {{(W-9){1'b0}}, g_8888};
    end else begin
      op_a = lo_565;
      op_b = hi_565;
    end
    prod_a = op_a * factor_w;
    prod_b = op_b * factor_w;
    if (ctrl.fmt == scd_pkg::FMT_ARGB8888) begin
      dimmed = ((prod_a & scd_pkg::MASK_8888_RB_OUT) >> 8) | (prod_b & scd_pkg::MASK_8888_G);
    end else begin
      dimmed = ((prod_a & scd_pkg::MASK_565_LO_OUT) >> 5) | (prod_b & scd_pkg::MASK_565_HI_OUT);
    end
  end

  // Final selection between blanking, copying and dimming.
  always_comb begin
    unique case (ctrl.mode)
      scd_pkg::MODE_BLANK: out_d_nxt = '0;
      scd_pkg::MODE_COPY:  out_d_nxt = s1_up_r;
      scd_pkg::MODE_DIM:   out_d_nxt = dimmed;
      default:             out_d_nxt = '0;
    endcase
  end

  // Valid bits are reset; payload registers load with their stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_up_r <= in_bus.upper_word;
      s1_lo_r <= in_bus.lower_word;
    end
    if (out_adv) begin
      out_d_r <= out_d_nxt;
    end
  end

  assign out_bus.valid    = out_v_r;
  assign out_bus.gap_word = out_d_r;

  // A blanked beat leaves the pipeline as zero.
  a_blank_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && out_adv && ctrl.mode == scd_pkg::MODE_BLANK) |=> (out_d_r == '0))
    else $error("blanked beat is not zero");

  // A copied beat leaves the pipeline as its upper word.
  a_copy_upper: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && out_adv && ctrl.mode == scd_pkg::MODE_COPY) |=> (out_d_r == $past(s1_up_r)))
    else $error("copied beat differs from upper word");

  // Dimmed ARGB8888 never carries alpha.
  a_no_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && out_adv && ctrl.mode == scd_pkg::MODE_DIM &&
     ctrl.fmt == scd_pkg::FMT_ARGB8888) |=> (out_d_r[31:24] == 8'd0))
    else $error("alpha byte set in dimmed beat");

  // A beat held in the first stage is not dropped while the result stalls.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !out_adv) |=> (s1_v_r && $stable(s1_up_r)))
    else $error("first stage lost a beat under stall");

endmodule

`default_nettype wire

// ----- dv/tb_scanline_dimmer_core.sv -----
// Self-checking testbench of the scanline dimmer core: directed and random pixel words.
`timescale 1ns / 1ps

module tb_scanline_dimmer_core;
  import scd_pkg::*;

  localparam int HALF_PERIOD    = 6;
  localparam int RESET_CYCLES   = 11;
  localparam int IDLE_PERCENT   = 35;
  localparam int RANDOM_BEATS   = 1350;
  localparam int HOLD_CYCLES    = 160;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 4;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  scd_in_if  in_bus ();
  scd_out_if out_bus ();

  scanline_dimmer_core u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_bus      (in_bus),
    .out_bus     (out_bus),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Our own copy of the registers, as the block should hold them.
  logic [PCT_W-1:0] pct_set    = '0;
  logic             interp_set = 1'b0;
  logic             fmt_set    = FMT_RGB565;

  // Gap words still owed by the block, oldest first.
  logic [WORD_W-1:0] gap_words_due [$];

  int errors           = 0;
  int beats_sent       = 0;
  int words_checked    = 0;
  int settings_applied = 0;
  int stall_cycles     = 0;
  int hold_left        = 0;
  bit tx_steady        = 1'b0;
  bit rx_steady        = 1'b0;
  bit hold_req         = 1'b0;

  always #HALF_PERIOD clk = ~clk;

  // Expected gap word for one pair of words under the current register copy.
  function automatic logic [WORD_W-1:0] dimmed_gap_word(input logic [WORD_W-1:0] up,
                                                        input logic [WORD_W-1:0] lo);
    logic [31:0] pct;
    logic [31:0] factor;
    logic [31:0] part_a;
    logic [31:0] part_b;
    logic [31:0] prod_a;
    logic [31:0] prod_b;
    pct = (pct_set > PCT_FULL) ? 32'd100 : {25'd0, pct_set};
    if (pct == 32'd100) return '0;
    if (pct == 32'd0) return up;
    if (fmt_set == FMT_ARGB8888) begin
      factor = ((32'd100 - pct) * 32'd256) / (interp_set ? 32'd200 : 32'd100);
      if (interp_set) begin
        part_a = (up & MASK_8888_RB_IN) + (lo & MASK_8888_RB_IN);
        part_b = ((up & MASK_8888_G) + (lo & MASK_8888_G)) >> 8;
      end else begin
        part_a = up & MASK_8888_RB_IN;
        part_b = (up & MASK_8888_G) >> 8;
      end
      prod_a = part_a * factor;
      prod_b = part_b * factor;
      return ((prod_a & MASK_8888_RB_OUT) >> 8) | (prod_b & MASK_8888_G);
    end
    factor = ((32'd100 - pct) * 32'd32) / (interp_set ? 32'd200 : 32'd100);
    if (interp_set) begin
      part_a = (up & MASK_565_LO_IN) + (lo & MASK_565_LO_IN);
      part_b = ((up >> 5) & MASK_565_HI_IN) + ((lo >> 5) & MASK_565_HI_IN);
    end else begin
      part_a = up & MASK_565_LO_IN;
      part_b = (up >> 5) & MASK_565_HI_IN;
    end
    prod_a = part_a * factor;
    prod_b = part_b * factor;
    return ((prod_a & MASK_565_LO_OUT) >> 5) | (prod_b & MASK_565_HI_OUT);
  endfunction

  // Pixel words with the all-zero and all-one words well represented.
  function automatic logic [WORD_W-1:0] random_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Offer one pair of words, with random idle cycles first, and record its gap word.
  task automatic send_word(input logic [WORD_W-1:0] up, input logic [WORD_W-1:0] lo);
    while (!tx_steady && $urandom_range(99) < IDLE_PERCENT) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.upper_word <= up;
    in_bus.lower_word <= lo;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    gap_words_due.push_back(dimmed_gap_word(up, lo));
    beats_sent++;
  endtask

  // Stop offering and wait until every owed gap word has come out.
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (gap_words_due.size() != 0);
  endtask

  // One APB transfer: setup, access, then an idle cycle.
  task automatic apb_transfer(input logic wr, input logic [1:0] idx,
                              input logic [31:0] wdata, output logic [31:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Read a register back and compare it with our copy.
  task automatic check_reg(input logic [1:0] idx);
    logic [31:0] got;
    logic [31:0] want;
    apb_transfer(1'b0, idx, '0, got);
    case (idx)
      REG_PERCENT: want = {25'd0, pct_set};
      REG_INTERP:  want = {31'd0, interp_set};
      default:     want = {31'd0, fmt_set};
    endcase
    if (got !== want) begin
      errors++;
      $display("%0t: register %0d read back: expected %h, actual %h", $time, idx, want, got);
    end
  endtask

  // Write a register with junk in the unused upper bits, then read it back.
  task automatic set_reg(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] data;
    logic [31:0] unused;
    data = $urandom();
    if (idx == REG_PERCENT) data[PCT_W-1:0] = value[PCT_W-1:0];
    else data[0] = value[0];
    apb_transfer(1'b1, idx, data, unused);
    case (idx)
      REG_PERCENT: pct_set    = data[PCT_W-1:0];
      REG_INTERP:  interp_set = data[0];
      default:     fmt_set    = data[0];
    endcase
    check_reg(idx);
  endtask

  // Registers are only rewritten once the block has nothing left in flight.
  task automatic apply_setting(input int pct, input bit interp, input bit fmt);
    wait_drained();
    set_reg(REG_PERCENT, pct);
    set_reg(REG_INTERP, interp);
    set_reg(REG_FORMAT, fmt);
    settings_applied++;
  endtask

  // A random setting, leaning towards the blanking, copying and saturating percentages.
  task automatic random_setting();
    int pct;
    case ($urandom_range(7))
      0:       pct = 0;
      1:       pct = 100;
      2:       pct = $urandom_range(127, 101);
      3:       pct = 1;
      4:       pct = 99;
      default: pct = $urandom_range(99, 1);
    endcase
    apply_setting(pct, $urandom_range(1), $urandom_range(1));
  endtask

  // After reset every register reads 0 and words are copied straight through.
  task automatic test_reset_state();
    check_reg(REG_PERCENT);
    check_reg(REG_INTERP);
    check_reg(REG_FORMAT);
    repeat (4) send_word(random_word(), random_word());
  endtask

  // Extreme words under each format and mode, full blanking, saturation and copying.
  task automatic test_directed();
    int pct_list [8]    = '{50, 50, 50, 50, 100, 127, 0, 1};
    bit interp_list [8] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
    bit fmt_list [8]    = '{FMT_RGB565, FMT_RGB565, FMT_ARGB8888, FMT_ARGB8888,
                            FMT_ARGB8888, FMT_RGB565, FMT_ARGB8888, FMT_RGB565};
    for (int i = 0; i < 8; i++) begin
      apply_setting(pct_list[i], interp_list[i], fmt_list[i]);
      send_word(32'hffff_ffff, 32'hffff_ffff);
      send_word(32'h0000_0000, 32'hffff_ffff);
      send_word($urandom(), $urandom());
    end
  endtask

  // Random words in phases of random length, a fresh setting for each phase.
  task automatic test_random();
    int target;
    target = beats_sent + RANDOM_BEATS;
    while (beats_sent < target) begin
      random_setting();
      repeat ($urandom_range(120, 40)) send_word(random_word(), random_word());
    end
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering.
  task automatic test_backpressure();
    wait_drained();
    tx_steady = 1'b1;
    @(negedge clk) hold_req = 1'b1;
    @(posedge clk);
    repeat (48) send_word(random_word(), random_word());
    tx_steady = 1'b0;
  endtask

  // A stretch in which neither side ever idles.
  task automatic test_steady_flow();
    random_setting();
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    repeat (120) send_word(random_word(), random_word());
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // Result side ready: random stalls, a counted hold-off on request, or always ready.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_bus.ready <= 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= rx_steady || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // Compare every result beat with the oldest gap word owed.
  always @(posedge clk) begin : check_gap_words
    logic [WORD_W-1:0] due;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (gap_words_due.size() == 0) begin
        errors++;
        $display("%0t: gap_word with nothing owed: expected none, actual %h",
                 $time, out_bus.gap_word);
      end else begin
        due = gap_words_due.pop_front();
        words_checked++;
        if (out_bus.gap_word !== due) begin
          errors++;
          $display("%0t: gap_word mismatch: expected %h, actual %h",
                   $time, due, out_bus.gap_word);
        end
      end
    end
  end

  // Give up when no beat has moved on either channel for too long.
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles, %0d gap words still owed",
               $time, stall_cycles, gap_words_due.size());
      $display("tb_scanline_dimmer_core: done, errors");
      $finish;
    end
  end

  // Reset once, run the tests in turn, then drain and report.
  initial begin
    rst_n             = 1'b0;
    cfg_psel          = 1'b0;
    cfg_penable       = 1'b0;
    cfg_pwrite        = 1'b0;
    cfg_paddr         = '0;
    cfg_pwdata        = '0;
    in_bus.valid      = 1'b0;
    in_bus.upper_word = '0;
    in_bus.lower_word = '0;
    out_bus.ready     = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_directed();
    test_random();
    test_backpressure();
    test_steady_flow();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (gap_words_due.size() != 0) begin
      errors++;
      $display("%0t: gap words left over: expected 0, actual %0d", $time, gap_words_due.size());
    end
    $display("Sent %0d word pairs under %0d register settings, both formats and modes,",
             beats_sent, settings_applied);
    $display("percentages 0 to 127 and a long result hold-off; %0d gap words checked.",
             words_checked);
    if (errors == 0) begin
      $display("tb_scanline_dimmer_core: done, clean");
    end else begin
      $display("tb_scanline_dimmer_core: done, errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/scd_pkg.sv
sv/scd_in_if.sv
sv/scd_out_if.sv
sv/scd_cfg_regs.sv
sv/scd_datapath.sv
sv/scanline_dimmer_core.sv
dv/tb_scanline_dimmer_core.sv
